[sv/adp_pkg.sv]
// Shared types, codes and helper functions for the data-processing ALU.
`default_nettype none

package adp_pkg;

   // Data-processing opcodes, instruction bits 24:21.
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   // Shift kinds, instruction bits 6:5.
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   // Condition codes, instruction bits 31:28.
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   // Result status codes.
   localparam logic [1:0] ST_EXEC      = 2'd0;
   localparam logic [1:0] ST_COND_FAIL = 2'd1;
   localparam logic [1:0] ST_UNDEF     = 2'd2;

   // Bit positions within an NZCV nibble.
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   // Register number of the program counter.
   localparam logic [3:0] REG_PC = 4'd15;

   // Operand 2 as produced by the shifter.
   typedef struct packed {
      logic [31:0] op2;
      logic        carry;
      logic        undef;
   } adp_shift_type;

   // Outcome of one instruction.
   typedef struct packed {
      logic [31:0] result_value;
      logic        write_dest;
      logic [3:0]  flags_out;
      logic [1:0]  status;
   } adp_result_type;

   // Rotate right by 0 to 31 places.
   function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] wide;
      wide = {x, x} >> n;
      return wide[31:0];
   endfunction

   // Condition test against the current NZCV flags.
   function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
      logic n, z, c, v, pass;
      n = f[FLAG_N];
      z = f[FLAG_Z];
      c = f[FLAG_C];
      v = f[FLAG_V];
      case (cond)
         COND_EQ: pass = z;
         COND_NE: pass = !z;
         COND_CS: pass = c;
         COND_CC: pass = !c;
         COND_MI: pass = n;
         COND_PL: pass = !n;
         COND_VS: pass = v;
         COND_VC: pass = !v;
         COND_HI: pass = c && !z;
         COND_LS: pass = !c || z;
         COND_GE: pass = (n == v);
         COND_LT: pass = (n != v);
         COND_GT: pass = !z && (n == v);
         COND_LE: pass = z || (n != v);
         COND_AL: pass = 1'b1;
         default: pass = 1'b0;
      endcase
      return pass;
   endfunction

endpackage

`default_nettype wire

[sv/adp_if.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface adp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr;
   logic [31:0] rn_value;
   logic [31:0] rm_value;
   logic [31:0] rs_value;
   logic        has_saved_status;
   logic [3:0]  saved_flags;

   modport source (output valid, instr, rn_value, rm_value, rs_value,
                   has_saved_status, saved_flags, input ready);
   modport sink (input valid, instr, rn_value, rm_value, rs_value,
                 has_saved_status, saved_flags, output ready);
endinterface

interface adp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic [3:0]  dest_index;
   logic        write_dest;
   logic [3:0]  flags_out;
   logic [1:0]  status;

   modport source (output valid, result_value, dest_index, write_dest,
                   flags_out, status, input ready);
   modport sink (input valid, result_value, dest_index, write_dest,
                 flags_out, status, output ready);
endinterface

`default_nettype wire

[sv/adp_shifter.sv]
// Barrel shifter that forms operand 2 and the shifter carry-out.
`default_nettype none

module adp_shifter (
   input  wire logic [31:0]           instr,
   input  wire logic [31:0]           rm_value,
   input  wire logic [31:0]           rs_value,
   input  wire logic                  carry_in,
   output adp_pkg::adp_shift_type     shift_out
);
   import adp_pkg::*;

   logic [1:0]  kind;
   logic [7:0]  amt;
   logic        use_rrx;
   logic        undef;
   logic        big;
   logic        exact32;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [31:0] sh_val;
   logic        sh_c;
   logic [31:0] ror_val;
   logic [4:0]  rot;
   logic [31:0] imm_val;

   // Decode the shift amount: register, immediate, or the zero-immediate forms.
   always_comb begin
      kind    = instr[6:5];
      amt     = '0;
      use_rrx = 1'b0;
      undef   = 1'b0;
      if (instr[4]) begin
         undef = instr[7];
         amt   = rs_value[7:0];
      end else if (instr[11:7] != 5'd0 || kind == SH_LSL) begin
         amt = {3'd0, instr[11:7]};
      end else if (kind == SH_ROR) begin
         use_rrx = 1'b1;
      end else begin
         amt = 8'd32;
      end
   end

   // The extra bit in each wide shift catches the last bit shifted out.
   assign big      = (amt[7:5] != 3'd0);
   assign exact32  = (amt == 8'd32);
   assign lsl_wide = {1'b0, rm_value} << amt[4:0];
   assign lsr_wide = {rm_value, 1'b0} >> amt[4:0];
   assign asr_wide = 33'($signed({rm_value, 1'b0}) >>> amt[4:0]);
   assign ror_val  = ror32(rm_value, amt[4:0]);

   // Register-operand shift, including the 32-and-above cases.
   always_comb begin
      sh_val = rm_value;
      sh_c   = carry_in;
      if (amt != 8'd0) begin
         case (kind)
            SH_LSL: begin
               if (!big) begin
                  sh_val = lsl_wide[31:0];
                  sh_c   = lsl_wide[32];
               end else begin
                  sh_val = '0;
                  sh_c   = exact32 & rm_value[0];
               end
            end
            SH_LSR: begin
               if (!big) begin
                  sh_val = lsr_wide[32:1];
                  sh_c   = lsr_wide[0];
               end else begin
                  sh_val = '0;
                  sh_c   = exact32 & rm_value[31];
               end
            end
            SH_ASR: begin
               if (!big) begin
                  sh_val = asr_wide[32:1];
                  sh_c   = asr_wide[0];
               end else begin
                  sh_val = {32{rm_value[31]}};
                  sh_c   = rm_value[31];
               end
            end
            default: begin
               sh_val = ror_val;
               sh_c   = ror_val[31];
            end
         endcase
      end
   end

   // Rotated 8-bit immediate.
   assign rot     = {instr[11:8], 1'b0};
   assign imm_val = ror32({24'd0, instr[7:0]}, rot);

   // Pick the operand form.
   always_comb begin
      shift_out.undef = 1'b0;
      if (instr[25]) begin
         shift_out.op2   = imm_val;
         shift_out.carry = (rot == 5'd0) ? carry_in : imm_val[31];
      end else if (use_rrx) begin
         shift_out.op2   = {carry_in, rm_value[31:1]};
         shift_out.carry = rm_value[0];
      end else begin
         shift_out.op2   = sh_val;
         shift_out.carry = sh_c;
         shift_out.undef = undef;
      end
   end

endmodule

`default_nettype wire

[sv/adp_alu.sv]
// Condition check, opcode evaluation and flag update for one instruction.
`default_nettype none

module adp_alu (
   input  wire logic [31:0]           instr,
   input  wire logic [31:0]           rn_value,
   input  wire adp_pkg::adp_shift_type shift_in,
   input  wire logic [3:0]            flags_cur,
   input  wire logic                  has_saved_status,
   input  wire logic [3:0]            saved_flags,
   output adp_pkg::adp_result_type    result_out
);
   import adp_pkg::*;

   logic [3:0]  op;
   logic [3:0]  rd;
   logic        s_bit;
   logic        cin;
   logic [31:0] op2;
   logic [31:0] add_a;
   logic [31:0] add_b;
   logic        add_c;
   logic [32:0] sum;
   logic        ovf;
   logic [31:0] alu_val;
   logic        logical;
   logic        compare;
   logic        pass;
   logic [3:0]  calc_flags;

   assign op    = instr[24:21];
   assign rd    = instr[15:12];
   assign s_bit = instr[20];
   assign cin   = flags_cur[FLAG_C];
   assign op2   = shift_in.op2;
   assign pass  = cond_pass(instr[31:28], flags_cur);

   // Adder operand selection for the arithmetic opcodes.
   always_comb begin
      add_a = rn_value;
      add_b = op2;
      add_c = 1'b0;
      case (op)
         OP_SUB, OP_CMP: begin
            add_b = ~op2;
            add_c = 1'b1;
         end
         OP_RSB: begin
            add_a = op2;
            add_b = ~rn_value;
            add_c = 1'b1;
         end
         OP_ADC: add_c = cin;
         OP_SBC: begin
            add_b = ~op2;
            add_c = cin;
         end
         OP_RSC: begin
            add_a = op2;
            add_b = ~rn_value;
            add_c = cin;
         end
         default: add_c = 1'b0;
      endcase
   end

   assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
   assign ovf = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);

   // Opcode result; logical opcodes take their carry from the shifter.
   always_comb begin
      logical = 1'b1;
      case (op)
         OP_AND, OP_TST: alu_val = rn_value & op2;
         OP_EOR, OP_TEQ: alu_val = rn_value ^ op2;
         OP_ORR:         alu_val = rn_value | op2;
         OP_MOV:         alu_val = op2;
         OP_BIC:         alu_val = rn_value & ~op2;
         OP_MVN:         alu_val = ~op2;
         default: begin
            alu_val = sum[31:0];
            logical = 1'b0;
         end
      endcase
   end

   assign compare = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);

   // NZCV from the result.
   always_comb begin
      calc_flags[FLAG_N] = alu_val[31];
      calc_flags[FLAG_Z] = (alu_val == 32'd0);
      calc_flags[FLAG_C] = logical ? shift_in.carry : sum[32];
      calc_flags[FLAG_V] = logical ? flags_cur[FLAG_V] : ovf;
   end

   // Final outcome: condition failure first, then undefined forms, then normal.
   always_comb begin
      result_out.result_value = '0;
      result_out.write_dest   = 1'b0;
      result_out.flags_out    = flags_cur;
      result_out.status       = ST_EXEC;
      if (!pass) begin
         result_out.status = ST_COND_FAIL;
      end else if (shift_in.undef) begin
         result_out.status = ST_UNDEF;
      end else if (!compare && s_bit && rd == REG_PC) begin
         // Flag restore from the saved status register.
         if (!has_saved_status) begin
            result_out.status = ST_UNDEF;
         end else begin
            result_out.result_value = alu_val;
            result_out.write_dest   = 1'b1;
            result_out.flags_out    = saved_flags;
         end
      end else begin
         result_out.result_value = alu_val;
         result_out.write_dest   = !compare;
         if (compare || s_bit) begin
            result_out.flags_out = calc_flags;
         end
      end
   end

endmodule

`default_nettype wire

[sv/arm_data_processing_alu_top.sv]
// Top level of the data-processing ALU: request register, ALU, response register.
//
//   Channel  Direction  Handshake          Carries
//   req_ch   in         valid/ready        instruction, Rn, Rm, Rs, saved status
//   rsp_ch   out        valid/ready        result, Rd, write enable, NZCV, status
//
// One request per cycle is sustained unless the response stalls. A request is
// captured in the request register, evaluated against the NZCV register, and
// moves on once the response register is empty or being taken. The NZCV
// register updates on that move, so the next request sees the new flags.
// Synchronous reset clears both valid bits and the flags. A stalled response
// holds the request register; a new request is taken only as it frees up.
`default_nettype none

module arm_data_processing_alu_top (
   input  wire logic clock,
   input  wire logic reset,
   adp_req_if.sink   req_ch,
   adp_rsp_if.source rsp_ch
);
   import adp_pkg::*;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   logic [31:0]    instr_ff;
   logic [31:0]    rn_ff;
   logic [31:0]    rm_ff;
   logic [31:0]    rs_ff;
   logic           has_saved_ff;
   logic [3:0]     saved_ff;
   logic [3:0]     flags_ff;
   logic [3:0]     flags_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [31:0]    out_result_ff;
   logic [3:0]     out_dest_ff;
   logic           out_write_ff;
   logic [3:0]     out_flags_ff;
   logic [1:0]     out_status_ff;
   logic           req_fire;
   logic           s1_adv;
   adp_shift_type  shift_res;
   adp_result_type alu_res;

   // Handshake control.
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ch.ready);
   assign flags_in     = s1_adv ? alu_res.flags_out : flags_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff     <= req_ch.instr;
         rn_ff        <= req_ch.rn_value;
         rm_ff        <= req_ch.rm_value;
         rs_ff        <= req_ch.rs_value;
         has_saved_ff <= req_ch.has_saved_status;
         saved_ff     <= req_ch.saved_flags;
      end
   end

   adp_shifter u_shifter (
      .instr     (instr_ff),
      .rm_value  (rm_ff),
      .rs_value  (rs_ff),
      .carry_in  (flags_ff[FLAG_C]),
      .shift_out (shift_res)
   );

   adp_alu u_alu (
      .instr            (instr_ff),
      .rn_value         (rn_ff),
      .shift_in         (shift_res),
      .flags_cur        (flags_ff),
      .has_saved_status (has_saved_ff),
      .saved_flags      (saved_ff),
      .result_out       (alu_res)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_result_ff <= alu_res.result_value;
         out_dest_ff   <= instr_ff[15:12];
         out_write_ff  <= alu_res.write_dest;
         out_flags_ff  <= alu_res.flags_out;
         out_status_ff <= alu_res.status;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = out_result_ff;
   assign rsp_ch.dest_index   = out_dest_ff;
   assign rsp_ch.write_dest   = out_write_ff;
   assign rsp_ch.flags_out    = out_flags_ff;
   assign rsp_ch.status       = out_status_ff;

`ifndef SYNTHESIS
   // A skipped or undefined instruction never writes and returns zero.
   a_no_write_on_skip: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_EXEC)
         |-> (!rsp_ch.write_dest && rsp_ch.result_value == 32'd0))
      else $error("skipped instruction writes a result");

   // The flags change only when a request moves to the response register.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(flags_ff))
      else $error("flags changed without a request advancing");

   // A request taken while the request register is full must replace a leaving one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_valid_ff) |-> s1_adv)
      else $error("request register overwritten");

   // The response flags match the flags register after a response is loaded.
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (out_flags_ff == flags_ff))
      else $error("response flags differ from the flags register");
`endif

endmodule

`default_nettype wire

[bench/arm_data_processing_alu_checker.sv]
`timescale 1ns / 100ps
// Checker for the data-processing ALU: executes each accepted request and compares responses.

module arm_data_processing_alu_checker (
   input  logic clock,
   input  logic reset,
   adp_req_if   req_ch,
   adp_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   outstanding
);
   import adp_pkg::*;

   typedef struct packed {
      logic [31:0] result_value;
      logic [3:0]  dest_index;
      logic        write_dest;
      logic [3:0]  flags_out;
      logic [1:0]  status;
   } alu_outcome_type;

   alu_outcome_type outcome_q[$];
   logic [3:0]      nzcv_now = 4'd0;
   int              mismatches = 0;
   int              queued = 0;

   assign mismatch_count = mismatches;
   assign outstanding = queued;

   // Condition field test against the live NZCV flags.
   function automatic logic condition_holds(input logic [3:0] cond, input logic [3:0] f);
      logic n, z, c, v, hold;
      n = f[FLAG_N];
      z = f[FLAG_Z];
      c = f[FLAG_C];
      v = f[FLAG_V];
      case (cond)
         COND_EQ: hold = z;
         COND_NE: hold = !z;
         COND_CS: hold = c;
         COND_CC: hold = !c;
         COND_MI: hold = n;
         COND_PL: hold = !n;
         COND_VS: hold = v;
         COND_VC: hold = !v;
         COND_HI: hold = c && !z;
         COND_LS: hold = !c || z;
         COND_GE: hold = (n == v);
         COND_LT: hold = (n != v);
         COND_GT: hold = !z && (n == v);
         COND_LE: hold = z || (n != v);
         COND_AL: hold = 1'b1;
         default: hold = 1'b0;
      endcase
      return hold;
   endfunction

   // Shifting left by 32 yields zero, so no special case is needed for k of zero.
   function automatic logic [31:0] rotate_right(input logic [31:0] x, input int unsigned k);
      k = k % 32;
      return (x >> k) | (x << (32 - k));
   endfunction

   // Barrel shifter on a decoded amount; returns {carry out, shifted value}.
   function automatic logic [32:0] barrel_shift(input logic [1:0] kind, input logic [31:0] rm,
                                                input int unsigned amt, input logic cin);
      logic        sign;
      logic [32:0] res;
      sign = rm[31];
      if (amt == 0) begin
         res = {cin, rm};
      end else begin
         case (kind)
            SH_LSL: begin
               if (amt < 32) res = {rm[32 - amt], rm << amt};
               else if (amt == 32) res = {rm[0], 32'd0};
               else res = 33'd0;
            end
            SH_LSR: begin
               if (amt < 32) res = {rm[amt - 1], rm >> amt};
               else if (amt == 32) res = {sign, 32'd0};
               else res = 33'd0;
            end
            SH_ASR: begin
               if (amt < 32) res = {rm[amt - 1], 32'($signed(rm) >>> amt)};
               else res = {sign, {32{sign}}};
            end
            default: begin
               // Rotation by a whole multiple of 32 leaves Rm and takes carry from bit 31.
               if (amt % 32 == 0) res = {sign, rm};
               else res = {rm[(amt % 32) - 1], rotate_right(rm, amt)};
            end
         endcase
      end
      return res;
   endfunction

   // Full adder over 32 bits; returns {overflow, carry, sum}.
   function automatic logic [33:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                             input logic cin);
      logic [32:0] sum;
      logic        ovf;
      sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      ovf = (a[31] == b[31]) && (sum[31] != a[31]);
      return {ovf, sum};
   endfunction

   // Executes one data-processing instruction against flags f.
   function automatic alu_outcome_type execute_dp(input logic [31:0] instr,
                                                  input logic [31:0] rn,
                                                  input logic [31:0] rm, input logic [31:0] rs,
                                                  input logic has_saved, input logic [3:0] saved,
                                                  input logic [3:0] f);
      alu_outcome_type o;
      logic [3:0]      op;
      logic [1:0]      kind;
      logic [4:0]      imm_amt;
      logic            cin, sc, c, v, logical, compare;
      logic [31:0]     op2, r;
      logic [32:0]     sh;
      logic [33:0]     sum;
      o.result_value = 32'd0;
      o.dest_index = instr[15:12];
      o.write_dest = 1'b0;
      o.flags_out = f;
      o.status = ST_EXEC;
      op = instr[24:21];
      kind = instr[6:5];
      cin = f[FLAG_C];
      logical = 1'b0;
      sum = 34'd0;
      r = 32'd0;
      if (!condition_holds(instr[31:28], f)) begin
         o.status = ST_COND_FAIL;
         return o;
      end

      // Operand 2 and the shifter carry.
      if (instr[25]) begin
         op2 = rotate_right({24'd0, instr[7:0]}, 2 * instr[11:8]);
         sh = {(instr[11:8] == 4'd0) ? cin : op2[31], op2};
      end else if (instr[4]) begin
         if (instr[7]) begin
            o.status = ST_UNDEF;
            return o;
         end
         sh = barrel_shift(kind, rm, rs[7:0], cin);
      end else begin
         imm_amt = instr[11:7];
         if (imm_amt != 5'd0 || kind == SH_LSL) sh = barrel_shift(kind, rm, imm_amt, cin);
         else if (kind == SH_ROR) sh = {rm[0], cin, rm[31:1]};
         else sh = barrel_shift(kind, rm, 32, cin);
      end
      {sc, op2} = sh;

      case (op)
         OP_AND, OP_TST: begin r = rn & op2; logical = 1'b1; end
         OP_EOR, OP_TEQ: begin r = rn ^ op2; logical = 1'b1; end
         OP_SUB, OP_CMP: sum = add_carry(rn, ~op2, 1'b1);
         OP_RSB:         sum = add_carry(op2, ~rn, 1'b1);
         OP_ADD, OP_CMN: sum = add_carry(rn, op2, 1'b0);
         OP_ADC:         sum = add_carry(rn, op2, cin);
         OP_SBC:         sum = add_carry(rn, ~op2, cin);
         OP_RSC:         sum = add_carry(op2, ~rn, cin);
         OP_ORR:         begin r = rn | op2; logical = 1'b1; end
         OP_MOV:         begin r = op2; logical = 1'b1; end
         OP_BIC:         begin r = rn & ~op2; logical = 1'b1; end
         default:        begin r = ~op2; logical = 1'b1; end
      endcase
      if (!logical) {v, c, r} = sum;
      else {v, c} = 2'b00;
      compare = (op >= OP_TST) && (op <= OP_CMN);

      // S with Rd as PC restores the saved flags, or is undefined without them.
      if (!compare && instr[20] && o.dest_index == REG_PC) begin
         if (!has_saved) begin
            o.status = ST_UNDEF;
            return o;
         end
         o.result_value = r;
         o.write_dest = 1'b1;
         o.flags_out = saved;
         return o;
      end

      o.result_value = r;
      o.write_dest = !compare;
      if (compare || instr[20]) begin
         o.flags_out[FLAG_N] = r[31];
         o.flags_out[FLAG_Z] = (r == 32'd0);
         o.flags_out[FLAG_C] = logical ? sc : c;
         o.flags_out[FLAG_V] = logical ? f[FLAG_V] : v;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $time, what);
      mismatches++;
   endtask

   // Responses are compared before the same edge's request is queued.
   always @(posedge clock) begin
      alu_outcome_type seen, want;
      if (reset) begin
         nzcv_now = 4'd0;
         outcome_q.delete();
         queued <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.result_value, rsp_ch.dest_index, rsp_ch.write_dest,
                    rsp_ch.flags_out, rsp_ch.status};
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding", seen));
            end else begin
               want = outcome_q.pop_front();
               if (seen.result_value !== want.result_value)
                  report_mismatch($sformatf("result_value got %h want %h",
                                            seen.result_value, want.result_value));
               if (seen.dest_index !== want.dest_index)
                  report_mismatch($sformatf("dest_index got %h want %h",
                                            seen.dest_index, want.dest_index));
               if (seen.write_dest !== want.write_dest)
                  report_mismatch($sformatf("write_dest got %b want %b",
                                            seen.write_dest, want.write_dest));
               if (seen.flags_out !== want.flags_out)
                  report_mismatch($sformatf("flags_out got %h want %h",
                                            seen.flags_out, want.flags_out));
               if (seen.status !== want.status)
                  report_mismatch($sformatf("status got %h want %h",
                                            seen.status, want.status));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = execute_dp(req_ch.instr, req_ch.rn_value, req_ch.rm_value, req_ch.rs_value,
                              req_ch.has_saved_status, req_ch.saved_flags, nzcv_now);
            nzcv_now = want.flags_out;
            outcome_q.push_back(want);
         end
         queued <= outcome_q.size();
      end
   end

endmodule

[bench/arm_data_processing_alu_top_test.sv]
`timescale 1ns / 100ps
// Bench top for the data-processing ALU: clock, reset, request stimulus and verdict.

module arm_data_processing_alu_top_test;
   import adp_pkg::*;

   localparam logic [3:0] COND_NV = 4'hF;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_REQUESTS = 700;

   logic clock;
   logic reset;
   logic no_idle = 1'b0;
   int   mismatch_count;
   int   outstanding;
   int   idle_cycles = 0;

   adp_req_if req_ch ();
   adp_rsp_if rsp_ch ();

   arm_data_processing_alu_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   arm_data_processing_alu_checker alu_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Packs the fields of a data-processing instruction word.
   function automatic logic [31:0] dp_word(input logic [3:0] cond, input logic imm,
                                           input logic [3:0] op, input logic s,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [11:0] operand);
      return {cond, 2'b00, imm, op, s, rn, rd, operand};
   endfunction

   // Register values lean on the sign and carry boundaries.
   function automatic logic [31:0] pick_operand();
      logic [31:0] val;
      case ($urandom_range(0, 5))
         0: val = 32'h0000_0000;
         1: val = 32'hFFFF_FFFF;
         2: val = 32'h8000_0000;
         3: val = 32'h7FFF_FFFF;
         default: val = $urandom;
      endcase
      return val;
   endfunction

   // Drives one request after a random gap and holds it until accepted.
   task automatic send_request(input logic [31:0] instr, input logic [31:0] rn,
                               input logic [31:0] rm, input logic [31:0] rs,
                               input logic has_saved, input logic [3:0] saved);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.instr <= instr;
      req_ch.rn_value <= rn;
      req_ch.rm_value <= rm;
      req_ch.rs_value <= rs;
      req_ch.has_saved_status <= has_saved;
      req_ch.saved_flags <= saved;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Random instruction, mostly unconditional and well formed.
   task automatic random_request();
      logic [31:0] instr, rs;
      instr = $urandom;
      rs = $urandom;
      if ($urandom_range(0, 9) < 6) instr[31:28] = COND_AL;
      if ($urandom_range(0, 3) != 0) instr[27:26] = 2'b00;
      if (!instr[25] && instr[4] && $urandom_range(0, 7) != 0) instr[7] = 1'b0;
      if (!instr[25] && !instr[4] && $urandom_range(0, 5) == 0) instr[11:7] = 5'd0;
      if ($urandom_range(0, 7) == 0) instr[15:12] = REG_PC;
      case ($urandom_range(0, 3))
         0: rs[7:0] = 8'($urandom_range(0, 31));
         1: rs[7:0] = 8'd32;
         2: rs[7:0] = 8'($urandom_range(33, 255));
         default: ;
      endcase
      send_request(instr, pick_operand(), pick_operand(), rs, 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
   endtask

   // Response side: random stalls before each response.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("no handshake for %0d cycles", IDLE_LIMIT);
         $display("arm_data_processing_alu_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Request stimulus and verdict.
   initial begin
      int         n;
      logic [3:0] op;
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.instr <= 32'd0;
      req_ch.rn_value <= 32'd0;
      req_ch.rm_value <= 32'd0;
      req_ch.rs_value <= 32'd0;
      req_ch.has_saved_status <= 1'b0;
      req_ch.saved_flags <= 4'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every opcode, alternating rotated immediates and immediate-shifted Rm. CMP runs
      // with S clear, and MVN lands on Rd 15 with S set, restoring the saved flags.
      for (n = 0; n < 16; n++) begin
         op = n[3:0];
         send_request(dp_word(COND_AL, op[0], op, op != OP_CMP, op, op,
                              op[0] ? {op, 8'hFF} : {op, 1'b0, op[2:1], 1'b0, 4'd2}),
                      op[1] ? 32'hFFFF_FFFF : 32'h8000_0000,
                      op[2] ? 32'h0000_0000 : 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, op);
      end

      // Never condition.
      send_request(dp_word(COND_NV, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd1, 12'h0FF),
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'hF);

      // Register shift with bit 7 set is undefined.
      send_request(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'd1, 4'd4,
                           {4'd2, 1'b1, SH_LSL, 1'b1, 4'd3}),
                   32'h1234_5678, 32'h8765_4321, 32'h0000_0004, 1'b1, 4'h5);

      // Register shifts by zero, exactly 32, above 32 and a multiple of 32 in rotate.
      send_request(dp_word(COND_AL, 1'b0, OP_MOVS_HELPER(), 1'b1, 4'd0, 4'd5,
                           {4'd2, 1'b0, SH_LSL, 1'b1, 4'd3}),
                   32'h0, 32'hC000_0001, 32'hFFFF_FF00, 1'b0, 4'h0);
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd6,
                           {4'd2, 1'b0, SH_LSR, 1'b1, 4'd3}),
                   32'h0, 32'h8000_0001, 32'h0000_0020, 1'b0, 4'h0);
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd7,
                           {4'd2, 1'b0, SH_ASR, 1'b1, 4'd3}),
                   32'h0, 32'h8000_0000, 32'h0000_00FF, 1'b0, 4'h0);
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd8,
                           {4'd2, 1'b0, SH_ROR, 1'b1, 4'd3}),
                   32'h0, 32'h8000_0001, 32'h0000_0040, 1'b0, 4'h0);

      // Immediate shift of zero: LSR #32, ASR #32 and rotate through carry.
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd9,
                           {5'd0, SH_LSR, 1'b0, 4'd3}),
                   32'h0, 32'h8000_0000, 32'h0, 1'b0, 4'h0);
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd10,
                           {5'd0, SH_ASR, 1'b0, 4'd3}),
                   32'h0, 32'h8000_0000, 32'h0, 1'b0, 4'h0);
      send_request(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd0, 4'd11,
                           {5'd0, SH_ROR, 1'b0, 4'd3}),
                   32'h0, 32'h0000_0003, 32'h0, 1'b0, 4'h0);

      // S with Rd 15 and no saved status is undefined.
      send_request(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, 4'd2, REG_PC, 12'h001),
                   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 4'hA);

      // Random requests, with stretches where neither side idles.
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 48) no_idle = 1'b1;
         else if (n % 64 == 0) no_idle = 1'b0;
         random_request();
      end
      req_ch.valid <= 1'b0;

      // Drain, then wait on for anything unexpected to show up.
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("arm_data_processing_alu_top: match");
      end else begin
         $display("arm_data_processing_alu_top: mismatch");
      end
      $finish;
   end

   // MOV opcode for the register-shift-by-zero request.
   function automatic logic [3:0] OP_MOVS_HELPER();
      return OP_MOV;
   endfunction

endmodule
